// ----- rtl/mlps_pkg.sv -----
// Shared constants for the two-layer sigmoid perceptron core.
// No dependencies.
package mlps_pkg;

    localparam int INPUT_COUNT  = 400;
    localparam int HIDDEN_COUNT = 25;
    localparam int CLASS_COUNT  = 10;

    localparam int HW_COLS  = INPUT_COUNT + 1;
    localparam int HW_DEPTH = HIDDEN_COUNT * HW_COLS;
    localparam int OW_COLS  = HIDDEN_COUNT + 1;
    localparam int OW_DEPTH = CLASS_COUNT * OW_COLS;

    localparam int HW_AW = $clog2(HW_DEPTH);
    localparam int OW_AW = $clog2(OW_DEPTH);
    localparam int H_AW  = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
    localparam int HC_W  = $clog2(HIDDEN_COUNT + 1);
    localparam int K_W   = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int PC_W  = $clog2(INPUT_COUNT + 1);

    localparam int SUM_W = 40;

    localparam int TAB_SIZE = 1024;
    localparam int TAB_AW   = 10;
    localparam int TAB_HALF = TAB_SIZE / 2;
    localparam int J_W      = $clog2(TAB_HALF);

    localparam logic [31:0] EXP_FIRST = 32'd4261543595;
    localparam logic [31:0] EXP_STEP  = 32'd4228380000;

    localparam int Q_W        = 17;
    localparam int DIV_DEN_W  = 33;
    localparam int DIV_NUM_W  = 49;

    localparam logic [1:0] OP_HW  = 2'd0;
    localparam logic [1:0] OP_OW  = 2'd1;
    localparam logic [1:0] OP_PIX = 2'd2;

endpackage

// ----- rtl/mlps_in_if.sv -----
// Input channel: weight writes and pixel beats.
// No dependencies.
interface mlps_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [4:0]         row_index;
    logic [8:0]         col_index;
    logic signed [15:0] value;
    logic               last_pixel;

    modport source (output valid, opcode, row_index, col_index, value, last_pixel,
                    input ready);
    modport sink   (input valid, opcode, row_index, col_index, value, last_pixel,
                    output ready);
endinterface

// ----- rtl/mlps_out_if.sv -----
// Output channel: one class activation per beat.
// No dependencies.
interface mlps_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  class_index;
    logic [15:0] activation;
    logic        last;

    modport source (output valid, class_index, activation, last, input ready);
    modport sink   (input valid, class_index, activation, last, output ready);
endinterface

// ----- rtl/mlps_div_unit.sv -----
// Restoring divider, one quotient bit per cycle, quotient known below 2^Q_W.
// Depends on mlps_pkg.
module mlps_div_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [mlps_pkg::DIV_NUM_W-1:0]     num,
    input  logic [mlps_pkg::DIV_DEN_W-1:0]     den,
    output logic                               busy,
    output logic [mlps_pkg::Q_W-1:0]           quo
);

    localparam int CNT_W = $clog2(mlps_pkg::Q_W + 1);

    logic [mlps_pkg::DIV_DEN_W:0]   rem_reg;
    logic [mlps_pkg::DIV_DEN_W-1:0] den_reg;
    logic [mlps_pkg::Q_W-1:0]       low_reg;
    logic [mlps_pkg::Q_W-1:0]       quo_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [mlps_pkg::DIV_DEN_W:0]   trial;
    logic                           ge;

    assign trial = {rem_reg[mlps_pkg::DIV_DEN_W-1:0], low_reg[mlps_pkg::Q_W-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign busy  = cnt_reg != '0;
    assign quo   = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            den_reg <= '0;
            low_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            rem_reg <= (mlps_pkg::DIV_DEN_W + 1)'(num[mlps_pkg::DIV_NUM_W-1:mlps_pkg::Q_W]);
            den_reg <= den;
            low_reg <= num[mlps_pkg::Q_W-1:0];
            quo_reg <= '0;
            cnt_reg <= CNT_W'(mlps_pkg::Q_W);
        end
        else if (busy)
        begin
            rem_reg <= ge ? (trial - {1'b0, den_reg}) : trial;
            quo_reg <= {quo_reg[mlps_pkg::Q_W-2:0], ge};
            low_reg <= {low_reg[mlps_pkg::Q_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- rtl/mlps_sig_table.sv -----
// Sigmoid table memory, built after reset from an exp recurrence and two dividers.
// Depends on mlps_pkg, mlps_div_unit.
module mlps_sig_table (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mlps_pkg::TAB_AW-1:0]  addr,
    output logic [15:0]                  data,
    output logic                         ready
);

    localparam logic [2:0] B_START = 3'd0;
    localparam logic [2:0] B_DIV   = 3'd1;
    localparam logic [2:0] B_WP    = 3'd2;
    localparam logic [2:0] B_WN    = 3'd3;
    localparam logic [2:0] B_DONE  = 3'd4;

    logic [15:0] tab_mem [mlps_pkg::TAB_SIZE];
    logic [15:0] data_reg;

    logic [2:0]                   bst_reg;
    logic [mlps_pkg::J_W-1:0]     j_reg;
    logic [31:0]                  e_reg;
    logic [63:0]                  prod_reg;

    logic [31:0]                  d_half;
    logic [mlps_pkg::DIV_NUM_W-1:0] pos_num;
    logic [mlps_pkg::DIV_NUM_W-1:0] neg_num;
    logic                         div_start;
    logic                         pos_busy;
    logic                         neg_busy;
    logic [mlps_pkg::Q_W-1:0]     pos_q;
    logic [mlps_pkg::Q_W-1:0]     neg_q;
    logic                         tab_we;
    logic [mlps_pkg::TAB_AW-1:0]  tab_wa;
    logic [15:0]                  tab_wd;

    assign d_half    = {1'b1, e_reg[31:1]};
    assign pos_num   = (mlps_pkg::DIV_NUM_W'(1) << 48) + mlps_pkg::DIV_NUM_W'(d_half);
    assign neg_num   = mlps_pkg::DIV_NUM_W'({e_reg, 16'b0}) + mlps_pkg::DIV_NUM_W'(d_half);
    assign div_start = bst_reg == B_START;
    assign ready     = bst_reg == B_DONE;
    assign data      = data_reg;

    mlps_div_unit u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (pos_num),
        .den   ({1'b1, e_reg}),
        .busy  (pos_busy),
        .quo   (pos_q)
    );

    mlps_div_unit u_neg (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (neg_num),
        .den   ({1'b1, e_reg}),
        .busy  (neg_busy),
        .quo   (neg_q)
    );

    always_comb
    begin
        tab_we = 1'b0;
        tab_wa = '0;
        tab_wd = '0;
        case (bst_reg)
            B_WP:
            begin
                tab_we = 1'b1;
                tab_wa = mlps_pkg::TAB_AW'(mlps_pkg::TAB_HALF) + mlps_pkg::TAB_AW'(j_reg);
                tab_wd = pos_q[mlps_pkg::Q_W-1] ? 16'hFFFF : pos_q[15:0];
            end
            B_WN:
            begin
                tab_we = 1'b1;
                tab_wa = mlps_pkg::TAB_AW'(mlps_pkg::TAB_HALF - 1) - mlps_pkg::TAB_AW'(j_reg);
                tab_wd = neg_q[mlps_pkg::Q_W-1] ? 16'hFFFF : neg_q[15:0];
            end
            default:
            begin
                tab_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_wa] <= tab_wd;
        end
        data_reg <= tab_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bst_reg  <= B_START;
            j_reg    <= '0;
            e_reg    <= mlps_pkg::EXP_FIRST;
            prod_reg <= '0;
        end
        else
        begin
            case (bst_reg)
                B_START:
                begin
                    bst_reg <= B_DIV;
                end
                B_DIV:
                begin
                    if (!pos_busy && !neg_busy)
                    begin
                        bst_reg <= B_WP;
                    end
                end
                B_WP:
                begin
                    prod_reg <= 64'(e_reg) * 64'(mlps_pkg::EXP_STEP);
                    bst_reg  <= B_WN;
                end
                B_WN:
                begin
                    e_reg <= 32'((prod_reg + (64'd1 << 31)) >> 32);
                    if (j_reg == mlps_pkg::J_W'(mlps_pkg::TAB_HALF - 1))
                    begin
                        bst_reg <= B_DONE;
                    end
                    else
                    begin
                        j_reg   <= j_reg + 1'b1;
                        bst_reg <= B_START;
                    end
                end
                default:
                begin
                    bst_reg <= B_DONE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/mlp_two_layer_sigmoid_forward_core.sv -----
// Top level of the two-layer sigmoid perceptron inference core.
// Depends on mlps_pkg, mlps_in_if, mlps_out_if, mlps_sig_table.
//
// Usage:
//   pix carries beats of three kinds: hidden weight write, output weight
//   write (column 0 is the bias) and pixel. A weight write leaves the core idle.
//   A pixel walks the hidden rows through the weight and sum memories, one
//   row per cycle behind a three-stage read/multiply/write pipeline; pix is
//   not taken again until the last row has been written back.
//   On a last pixel, the hidden layer finishes row by row through the
//   sigmoid table (read, index, lookup, write), then each class runs its
//   multiply-accumulate and lookup; res sends one beat per class, the final
//   one marked last.
//   After reset the sigmoid table is built, during which pix.ready stays
//   low. Hidden sums and the pixel count clear at reset and at the end of
//   each sample. res has one output register; a stalled receiver holds the
//   beat, and the core waits before loading the next class. pix is taken
//   only while idle.
module mlp_two_layer_sigmoid_forward_core (
    input  logic        clk,
    input  logic        rst_n,
    mlps_in_if.sink     pix,
    mlps_out_if.source  res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACC   = 3'd1;
    localparam logic [2:0] S_HID   = 3'd2;
    localparam logic [2:0] S_OACC  = 3'd3;
    localparam logic [2:0] S_OSIG  = 3'd4;
    localparam logic [2:0] S_OTAB  = 3'd5;
    localparam logic [2:0] S_OEMIT = 3'd6;

    localparam int HID_FRAC = 23;
    localparam int OUT_FRAC = 27;
    localparam logic signed [mlps_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(mlps_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [mlps_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(mlps_pkg::SUM_W-1){1'b0}}};

    function automatic logic signed [mlps_pkg::SUM_W-1:0] sat_sum(
        input logic signed [mlps_pkg::SUM_W:0] s);
        logic signed [mlps_pkg::SUM_W-1:0] r;
        begin
            if (s > (mlps_pkg::SUM_W + 1)'(SUM_MAX))
                r = SUM_MAX;
            else if (s < (mlps_pkg::SUM_W + 1)'(SUM_MIN))
                r = SUM_MIN;
            else
                r = s[mlps_pkg::SUM_W-1:0];
            return r;
        end
    endfunction

    function automatic logic [mlps_pkg::TAB_AW-1:0] hid_index(
        input logic signed [mlps_pkg::SUM_W-1:0] z);
        logic signed [mlps_pkg::SUM_W:0] t;
        logic [mlps_pkg::TAB_AW-1:0]     r;
        begin
            t = (mlps_pkg::SUM_W + 1)'(z) + ((mlps_pkg::SUM_W + 1)'(1) <<< (HID_FRAC + 3));
            if (t < 0)
                r = '0;
            else if (t >= ((mlps_pkg::SUM_W + 1)'(1) <<< (HID_FRAC + 4)))
                r = '1;
            else
                r = t[HID_FRAC+3:HID_FRAC-6];
            return r;
        end
    endfunction

    function automatic logic [mlps_pkg::TAB_AW-1:0] out_index(
        input logic signed [mlps_pkg::SUM_W-1:0] z);
        logic signed [mlps_pkg::SUM_W:0] t;
        logic [mlps_pkg::TAB_AW-1:0]     r;
        begin
            t = (mlps_pkg::SUM_W + 1)'(z) + ((mlps_pkg::SUM_W + 1)'(1) <<< (OUT_FRAC + 3));
            if (t < 0)
                r = '0;
            else if (t >= ((mlps_pkg::SUM_W + 1)'(1) <<< (OUT_FRAC + 4)))
                r = '1;
            else
                r = t[OUT_FRAC+3:OUT_FRAC-6];
            return r;
        end
    endfunction

    // memories
    logic signed [15:0]                hw_mem  [mlps_pkg::HW_DEPTH];
    logic signed [15:0]                ow_mem  [mlps_pkg::OW_DEPTH];
    logic signed [mlps_pkg::SUM_W-1:0] sum_mem [mlps_pkg::HIDDEN_COUNT];
    logic [15:0]                       act_mem [mlps_pkg::HIDDEN_COUNT];

    logic signed [15:0]                hw_rd_reg;
    logic signed [15:0]                ow_rd_reg;
    logic signed [mlps_pkg::SUM_W-1:0] sum_rd_reg;
    logic [15:0]                       act_rd_reg;

    // control
    logic [2:0]                        st_reg;
    logic [1:0]                        sub_reg;
    logic [mlps_pkg::PC_W-1:0]         pc_reg;
    logic [mlps_pkg::HIDDEN_COUNT-1:0] sv_reg;
    logic [mlps_pkg::HC_W-1:0]         h_reg;
    logic                              iss_reg;
    logic [mlps_pkg::HW_AW-1:0]        hw_ra_reg;
    logic signed [15:0]                v_reg;
    logic                              last_reg;

    logic                              p1_v_reg;
    logic [mlps_pkg::H_AW-1:0]         p1_h_reg;
    logic                              p2_v_reg;
    logic [mlps_pkg::H_AW-1:0]         p2_h_reg;
    logic signed [mlps_pkg::SUM_W-1:0] p2_sum_reg;
    logic signed [31:0]                p2_prod_reg;

    logic [mlps_pkg::K_W-1:0]          k_reg;
    logic [mlps_pkg::HC_W-1:0]         oj_reg;
    logic                              o_iss_reg;
    logic [mlps_pkg::OW_AW-1:0]        ow_base_reg;
    logic                              o1_v_reg;
    logic                              o1_b_reg;
    logic                              o1_last_reg;
    logic                              o2_v_reg;
    logic                              o2_last_reg;
    logic signed [mlps_pkg::SUM_W-1:0] o2_prod_reg;
    logic signed [mlps_pkg::SUM_W-1:0] acc_reg;
    logic [mlps_pkg::TAB_AW-1:0]       tab_idx_reg;

    logic                              res_v_reg;
    logic [3:0]                        res_cls_reg;
    logic [15:0]                       res_act_reg;
    logic                              res_last_reg;

    // combinational
    logic                              tab_rdy;
    logic [15:0]                       tab_data;
    logic                              pix_acc;
    logic                              hw_we;
    logic [mlps_pkg::HW_AW-1:0]        hw_wa;
    logic                              ow_we;
    logic [mlps_pkg::OW_AW-1:0]        ow_wa;
    logic [mlps_pkg::OW_AW-1:0]        ow_ra;
    logic [mlps_pkg::H_AW-1:0]         h_idx;
    logic [mlps_pkg::H_AW-1:0]         act_ra;
    logic                              act_we;
    logic signed [mlps_pkg::SUM_W-1:0] p1_sum;
    logic signed [mlps_pkg::SUM_W-1:0] hid_z;
    logic signed [32:0]                o_mul;
    logic                              res_load;

    mlps_sig_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (tab_idx_reg),
        .data  (tab_data),
        .ready (tab_rdy)
    );

    assign pix.ready = (st_reg == S_IDLE) && tab_rdy;
    assign pix_acc   = pix.valid && pix.ready;

    assign hw_we = pix_acc && (pix.opcode == mlps_pkg::OP_HW)
                   && (32'(pix.row_index) < mlps_pkg::HIDDEN_COUNT)
                   && (32'(pix.col_index) <= mlps_pkg::INPUT_COUNT);
    assign hw_wa = mlps_pkg::HW_AW'(32'(pix.row_index) * mlps_pkg::HW_COLS
                                    + 32'(pix.col_index));
    assign ow_we = pix_acc && (pix.opcode == mlps_pkg::OP_OW)
                   && (32'(pix.row_index) < mlps_pkg::CLASS_COUNT)
                   && (32'(pix.col_index) <= mlps_pkg::HIDDEN_COUNT);
    assign ow_wa = mlps_pkg::OW_AW'(32'(pix.row_index) * mlps_pkg::OW_COLS
                                    + 32'(pix.col_index));

    assign h_idx  = h_reg[mlps_pkg::H_AW-1:0];
    assign ow_ra  = ow_base_reg + mlps_pkg::OW_AW'(oj_reg);
    assign act_ra = mlps_pkg::H_AW'(oj_reg - 1'b1);
    assign act_we = (st_reg == S_HID) && (sub_reg == 2'd3);

    assign p1_sum = sv_reg[p1_h_reg] ? sum_rd_reg : '0;
    assign hid_z  = sat_sum((mlps_pkg::SUM_W + 1)'($signed(sv_reg[h_idx] ? sum_rd_reg : '0))
                            + ((mlps_pkg::SUM_W + 1)'(hw_rd_reg) <<< 12));
    assign o_mul  = ow_rd_reg * $signed({1'b0, act_rd_reg});

    assign res_load = (st_reg == S_OEMIT) && (!res_v_reg || res.ready);

    assign res.valid       = res_v_reg;
    assign res.class_index = res_cls_reg;
    assign res.activation  = res_act_reg;
    assign res.last        = res_last_reg;

    always_ff @(posedge clk)
    begin
        if (hw_we)
        begin
            hw_mem[hw_wa] <= pix.value;
        end
        hw_rd_reg <= hw_mem[hw_ra_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ow_we)
        begin
            ow_mem[ow_wa] <= pix.value;
        end
        ow_rd_reg <= ow_mem[ow_ra];
    end

    always_ff @(posedge clk)
    begin
        if (p2_v_reg)
        begin
            sum_mem[p2_h_reg] <= sat_sum((mlps_pkg::SUM_W + 1)'(p2_sum_reg)
                                         + (mlps_pkg::SUM_W + 1)'(p2_prod_reg));
        end
        sum_rd_reg <= sum_mem[h_idx];
    end

    always_ff @(posedge clk)
    begin
        if (act_we)
        begin
            act_mem[h_idx] <= tab_data;
        end
        act_rd_reg <= act_mem[act_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            sub_reg      <= '0;
            pc_reg       <= '0;
            sv_reg       <= '0;
            h_reg        <= '0;
            iss_reg      <= 1'b0;
            hw_ra_reg    <= '0;
            v_reg        <= '0;
            last_reg     <= 1'b0;
            p1_v_reg     <= 1'b0;
            p1_h_reg     <= '0;
            p2_v_reg     <= 1'b0;
            p2_h_reg     <= '0;
            p2_sum_reg   <= '0;
            p2_prod_reg  <= '0;
            k_reg        <= '0;
            oj_reg       <= '0;
            o_iss_reg    <= 1'b0;
            ow_base_reg  <= '0;
            o1_v_reg     <= 1'b0;
            o1_b_reg     <= 1'b0;
            o1_last_reg  <= 1'b0;
            o2_v_reg     <= 1'b0;
            o2_last_reg  <= 1'b0;
            o2_prod_reg  <= '0;
            acc_reg      <= '0;
            tab_idx_reg  <= '0;
            res_v_reg    <= 1'b0;
            res_cls_reg  <= '0;
            res_act_reg  <= '0;
            res_last_reg <= 1'b0;
        end
        else
        begin
            // hidden accumulate pipeline
            p1_v_reg    <= (st_reg == S_ACC) && iss_reg;
            p2_v_reg    <= p1_v_reg;
            p2_h_reg    <= p1_h_reg;
            p2_sum_reg  <= p1_sum;
            p2_prod_reg <= hw_rd_reg * v_reg;

            // output accumulate pipeline
            o1_v_reg    <= (st_reg == S_OACC) && o_iss_reg;
            o2_v_reg    <= o1_v_reg;
            o2_last_reg <= o1_last_reg;
            o2_prod_reg <= o1_b_reg ? (mlps_pkg::SUM_W'(ow_rd_reg) <<< 16)
                                    : mlps_pkg::SUM_W'(o_mul);

            if (res_load)
            begin
                res_v_reg    <= 1'b1;
                res_cls_reg  <= 4'(k_reg);
                res_act_reg  <= tab_data;
                res_last_reg <= 32'(k_reg) == mlps_pkg::CLASS_COUNT - 1;
            end
            else if (res.ready)
            begin
                res_v_reg <= 1'b0;
            end

            case (st_reg)
                S_IDLE:
                begin
                    if (pix_acc && (pix.opcode == mlps_pkg::OP_PIX))
                    begin
                        v_reg    <= pix.value;
                        last_reg <= pix.last_pixel;
                        h_reg    <= '0;
                        sub_reg  <= '0;
                        if (32'(pc_reg) < mlps_pkg::INPUT_COUNT)
                        begin
                            hw_ra_reg <= mlps_pkg::HW_AW'(pc_reg) + 1'b1;
                            iss_reg   <= 1'b1;
                            st_reg    <= S_ACC;
                        end
                        else if (pix.last_pixel)
                        begin
                            hw_ra_reg <= '0;
                            st_reg    <= S_HID;
                        end
                    end
                end
                S_ACC:
                begin
                    if (iss_reg)
                    begin
                        p1_h_reg  <= h_idx;
                        h_reg     <= h_reg + 1'b1;
                        hw_ra_reg <= hw_ra_reg + mlps_pkg::HW_AW'(mlps_pkg::HW_COLS);
                        if (32'(h_reg) == mlps_pkg::HIDDEN_COUNT - 1)
                        begin
                            iss_reg <= 1'b0;
                        end
                    end
                    if (p2_v_reg)
                    begin
                        sv_reg[p2_h_reg] <= 1'b1;
                        if (32'(p2_h_reg) == mlps_pkg::HIDDEN_COUNT - 1)
                        begin
                            pc_reg    <= pc_reg + 1'b1;
                            h_reg     <= '0;
                            sub_reg   <= '0;
                            hw_ra_reg <= '0;
                            st_reg    <= last_reg ? S_HID : S_IDLE;
                        end
                    end
                end
                S_HID:
                begin
                    case (sub_reg)
                        2'd1:
                        begin
                            tab_idx_reg <= hid_index(hid_z);
                            sub_reg     <= 2'd2;
                        end
                        2'd3:
                        begin
                            sub_reg <= 2'd0;
                            if (32'(h_reg) == mlps_pkg::HIDDEN_COUNT - 1)
                            begin
                                k_reg       <= '0;
                                oj_reg      <= '0;
                                ow_base_reg <= '0;
                                acc_reg     <= '0;
                                o_iss_reg   <= 1'b1;
                                st_reg      <= S_OACC;
                            end
                            else
                            begin
                                h_reg     <= h_reg + 1'b1;
                                hw_ra_reg <= hw_ra_reg + mlps_pkg::HW_AW'(mlps_pkg::HW_COLS);
                            end
                        end
                        default:
                        begin
                            sub_reg <= sub_reg + 1'b1;
                        end
                    endcase
                end
                S_OACC:
                begin
                    if (o_iss_reg)
                    begin
                        o1_b_reg    <= oj_reg == '0;
                        o1_last_reg <= 32'(oj_reg) == mlps_pkg::HIDDEN_COUNT;
                        if (32'(oj_reg) == mlps_pkg::HIDDEN_COUNT)
                        begin
                            o_iss_reg <= 1'b0;
                        end
                        else
                        begin
                            oj_reg <= oj_reg + 1'b1;
                        end
                    end
                    if (o2_v_reg)
                    begin
                        acc_reg <= acc_reg + o2_prod_reg;
                        if (o2_last_reg)
                        begin
                            st_reg <= S_OSIG;
                        end
                    end
                end
                S_OSIG:
                begin
                    tab_idx_reg <= out_index(acc_reg);
                    st_reg      <= S_OTAB;
                end
                S_OTAB:
                begin
                    st_reg <= S_OEMIT;
                end
                S_OEMIT:
                begin
                    if (res_load)
                    begin
                        if (32'(k_reg) == mlps_pkg::CLASS_COUNT - 1)
                        begin
                            sv_reg <= '0;
                            pc_reg <= '0;
                            st_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg       <= k_reg + 1'b1;
                            ow_base_reg <= ow_base_reg + mlps_pkg::OW_AW'(mlps_pkg::OW_COLS);
                            oj_reg      <= '0;
                            acc_reg     <= '0;
                            o_iss_reg   <= 1'b1;
                            st_reg      <= S_OACC;
                        end
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_IDLE) |-> (!p1_v_reg && !p2_v_reg && !o1_v_reg && !o2_v_reg))
        else $error("pipeline busy while idle");

    a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pc_reg) <= mlps_pkg::INPUT_COUNT)
        else $error("pixel count beyond input count");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (32'(k_reg) == mlps_pkg::CLASS_COUNT - 1))
        |=> (st_reg == S_IDLE && pc_reg == '0 && sv_reg == '0))
        else $error("sample state not cleared after final class");

    a_ready_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        pix.ready |-> tab_rdy)
        else $error("input taken before sigmoid table built");
`endif

endmodule
